// File: hdl/assert_macros.svh
// assertion macros used by the scheduler top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds on every clock edge outside reset
`define PRSQ_ASSERT(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

// consequent holds in the cycle of the antecedent
`define PRSQ_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`endif

// File: hdl/prsq_pkg.sv
// package with constants, entry types and address helpers of the scheduler
`default_nettype none
package prsq_pkg;

   localparam int RDY_DEPTH = 16;
   localparam int SLP_DEPTH = 16;
   localparam int PRIO_MAX  = 63;

   localparam int RDY_AW = (RDY_DEPTH > 1) ? $clog2(RDY_DEPTH) : 1;
   localparam int SLP_AW = (SLP_DEPTH > 1) ? $clog2(SLP_DEPTH) : 1;
   localparam int RDY_CW = $clog2(RDY_DEPTH + 1);
   localparam int SLP_CW = $clog2(SLP_DEPTH + 1);

   localparam int TASK_W = 8;
   localparam int PRIO_W = 6;
   localparam int TIME_W = 63;

   localparam logic [2:0] MODE_UNBLOCK = 3'd0;
   localparam logic [2:0] MODE_SLEEP   = 3'd1;
   localparam logic [2:0] MODE_TICK    = 3'd2;
   localparam logic [2:0] MODE_YIELD   = 3'd3;
   localparam logic [2:0] MODE_SETPRIO = 3'd4;
   localparam logic [2:0] MODE_BLOCK   = 3'd5;

   localparam logic [1:0] ERR_NONE       = 2'd0;
   localparam logic [1:0] ERR_READY_FULL = 2'd1;
   localparam logic [1:0] ERR_SLEEP_FULL = 2'd2;

   localparam logic       KIND_WOKEN  = 1'b0;
   localparam logic       KIND_STATUS = 1'b1;

   localparam logic [TASK_W-1:0] RESET_TASK = 8'd1;
   localparam logic [PRIO_W-1:0] RESET_PRIO = 6'd31;
   localparam logic [7:0]        RESET_SLICE = 8'd4;
   localparam logic [7:0]        SLICE_SAT   = 8'd255;

   typedef struct packed {
      logic [TASK_W-1:0] task_id;
      logic [PRIO_W-1:0] prio;
   } rdy_entry_type;

   typedef struct packed {
      logic [TASK_W-1:0] task_id;
      logic [PRIO_W-1:0] prio;
      logic [TIME_W-1:0] wake;
   } slp_entry_type;

   function automatic logic [RDY_AW-1:0] rdy_addr(input logic [RDY_AW-1:0] head,
                                                  input logic [RDY_CW-1:0] idx);
      logic [RDY_CW:0] s;
      s = {{(RDY_CW + 1 - RDY_AW){1'b0}}, head} + {1'b0, idx};
      if (s >= (RDY_CW + 1)'(RDY_DEPTH)) begin
         s = s - (RDY_CW + 1)'(RDY_DEPTH);
      end
      return s[RDY_AW-1:0];
   endfunction

   function automatic logic [SLP_AW-1:0] slp_addr(input logic [SLP_AW-1:0] head,
                                                  input logic [SLP_CW-1:0] idx);
      logic [SLP_CW:0] s;
      s = {{(SLP_CW + 1 - SLP_AW){1'b0}}, head} + {1'b0, idx};
      if (s >= (SLP_CW + 1)'(SLP_DEPTH)) begin
         s = s - (SLP_CW + 1)'(SLP_DEPTH);
      end
      return s[SLP_AW-1:0];
   endfunction

   function automatic logic [PRIO_W-1:0] sat_prio(input logic [PRIO_W-1:0] p);
      if ({2'b00, p} > 8'(PRIO_MAX)) begin
         return PRIO_W'(PRIO_MAX);
      end
      return p;
   endfunction

endpackage
`default_nettype wire

// File: hdl/prsq_ram.sv
// generic single-port-write, single-port-read ram with registered read data
`default_nettype none
module prsq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire                                       clock,
   input  wire                                       we,
   input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire  [WIDTH-1:0]                          wdata,
   input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                          rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule
`default_nettype wire

// File: hdl/priority_ready_and_sleep_queue_top.sv
// priority scheduler with ready queue and timed sleep queue
//
// channel   | ports                     | handshake
// request   | start, busy, req_*        | taken when start and not busy
// response  | rsp_strobe, rsp_*         | one cycle per response, no stall
// config    | psel penable pwrite paddr | apb write, pready always high
//
// busy stays high through the whole event, with each entry moved by an ordered
// insert; a tick also covers each woken task and the moves of its insert
// the status is on the response ports in the same cycle that busy falls
// queues are circular buffers in rams with one write and one read port
// reset is synchronous; clears counts, loads the reset task; no ram sweep
// the response side cannot stall; busy stays high until the status is sent
`default_nettype none
`include "assert_macros.svh"
module priority_ready_and_sleep_queue_top import prsq_pkg::*; (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   output logic               busy,
   input  wire  [2:0]         req_mode,
   input  wire  [TASK_W-1:0]  req_thread_id,
   input  wire  [PRIO_W-1:0]  req_priority_req,
   input  wire  [TIME_W-1:0]  req_wake_time,
   input  wire  [TIME_W-1:0]  req_now_time,
   output logic               rsp_strobe,
   output logic               rsp_kind,
   output logic [TASK_W-1:0]  rsp_task_out,
   output logic [PRIO_W-1:0]  rsp_task_priority,
   output logic               rsp_idle_running,
   output logic [1:0]         rsp_error,
   output logic               rsp_last,
   input  wire                psel,
   input  wire                penable,
   input  wire                pwrite,
   input  wire  [2:0]         paddr,
   input  wire  [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   typedef enum logic [4:0] {
      ST_IDLE, ST_EXEC, ST_PUSH_RD, ST_PUSH_CMP, ST_SLP_RD, ST_SLP_CMP,
      ST_WK_RD, ST_WK_CHK, ST_WK_EMIT, ST_SLICE, ST_YLD, ST_PRE, ST_DISP,
      ST_HD_RD, ST_HD_CHK, ST_FIN, ST_STATUS
   } state_type;

   typedef enum logic [1:0] {RET_PRE, RET_WAKE, RET_FIN} ret_type;
   typedef enum logic [1:0] {AFT_TAKE, AFT_YLD, AFT_PRE} aft_type;

   state_type state_ff, state_in;
   ret_type   ret_ff, ret_in;
   aft_type   aft_ff, aft_in;

   logic [7:0]        slice_cfg_ff, slice_cfg_in;
   logic [TASK_W-1:0] run_task_ff, run_task_in;
   logic [PRIO_W-1:0] run_prio_ff, run_prio_in;
   logic              run_idle_ff, run_idle_in;
   logic [7:0]        slice_ff, slice_in;
   logic [RDY_AW-1:0] rhead_ff, rhead_in;
   logic [RDY_CW-1:0] rcount_ff, rcount_in;
   logic [SLP_AW-1:0] shead_ff, shead_in;
   logic [SLP_CW-1:0] scount_ff, scount_in;

   logic [2:0]        op_mode_ff, op_mode_in;
   logic [TASK_W-1:0] op_tid_ff, op_tid_in;
   logic [PRIO_W-1:0] op_prio_ff, op_prio_in;
   logic [TIME_W-1:0] op_wake_ff, op_wake_in;
   logic [TIME_W-1:0] op_now_ff, op_now_in;
   logic [1:0]        err_ff, err_in;
   logic              wk_err_ff, wk_err_in;
   logic [TASK_W-1:0] push_task_ff, push_task_in;
   logic [PRIO_W-1:0] push_prio_ff, push_prio_in;
   logic [RDY_CW-1:0] push_idx_ff, push_idx_in;
   logic [SLP_CW-1:0] slp_idx_ff, slp_idx_in;

   logic              out_strobe_ff, out_strobe_in;
   logic              out_kind_ff, out_kind_in;
   logic [TASK_W-1:0] out_task_ff, out_task_in;
   logic [PRIO_W-1:0] out_prio_ff, out_prio_in;
   logic              out_idle_ff, out_idle_in;
   logic [1:0]        out_err_ff, out_err_in;
   logic              out_last_ff, out_last_in;

   logic              rdy_we;
   logic [RDY_AW-1:0] rdy_waddr, rdy_raddr;
   rdy_entry_type     rdy_wdata, rdy_rdata;
   logic              slp_we;
   logic [SLP_AW-1:0] slp_waddr, slp_raddr;
   slp_entry_type     slp_wdata, slp_rdata;

   logic [7:0]        slice_next;

   prsq_ram #(.WIDTH($bits(rdy_entry_type)), .DEPTH(RDY_DEPTH)) u_rdy_ram (
      .clock(clock), .we(rdy_we), .waddr(rdy_waddr), .wdata(rdy_wdata),
      .raddr(rdy_raddr), .rdata(rdy_rdata)
   );

   prsq_ram #(.WIDTH($bits(slp_entry_type)), .DEPTH(SLP_DEPTH)) u_slp_ram (
      .clock(clock), .we(slp_we), .waddr(slp_waddr), .wdata(slp_wdata),
      .raddr(slp_raddr), .rdata(slp_rdata)
   );

   assign busy   = (state_ff != ST_IDLE);
   assign pready = 1'b1;
   assign prdata = paddr[2] ? 32'd0 : {24'd0, slice_cfg_ff};

   assign rsp_strobe        = out_strobe_ff;
   assign rsp_kind          = out_kind_ff;
   assign rsp_task_out      = out_task_ff;
   assign rsp_task_priority = out_prio_ff;
   assign rsp_idle_running  = out_idle_ff;
   assign rsp_error         = out_err_ff;
   assign rsp_last          = out_last_ff;

   assign slice_next = (slice_ff == SLICE_SAT) ? SLICE_SAT : slice_ff + 8'd1;

   always_comb begin
      state_in      = state_ff;
      ret_in        = ret_ff;
      aft_in        = aft_ff;
      slice_cfg_in  = slice_cfg_ff;
      run_task_in   = run_task_ff;
      run_prio_in   = run_prio_ff;
      run_idle_in   = run_idle_ff;
      slice_in      = slice_ff;
      rhead_in      = rhead_ff;
      rcount_in     = rcount_ff;
      shead_in      = shead_ff;
      scount_in     = scount_ff;
      op_mode_in    = op_mode_ff;
      op_tid_in     = op_tid_ff;
      op_prio_in    = op_prio_ff;
      op_wake_in    = op_wake_ff;
      op_now_in     = op_now_ff;
      err_in        = err_ff;
      wk_err_in     = wk_err_ff;
      push_task_in  = push_task_ff;
      push_prio_in  = push_prio_ff;
      push_idx_in   = push_idx_ff;
      slp_idx_in    = slp_idx_ff;
      out_strobe_in = 1'b0;
      out_kind_in   = out_kind_ff;
      out_task_in   = out_task_ff;
      out_prio_in   = out_prio_ff;
      out_idle_in   = out_idle_ff;
      out_err_in    = out_err_ff;
      out_last_in   = out_last_ff;
      rdy_we        = 1'b0;
      rdy_waddr     = rdy_addr(rhead_ff, push_idx_ff);
      rdy_wdata     = '{task_id: push_task_ff, prio: push_prio_ff};
      rdy_raddr     = rdy_addr(rhead_ff, '0);
      slp_we        = 1'b0;
      slp_waddr     = slp_addr(shead_ff, slp_idx_ff);
      slp_wdata     = '{task_id: run_task_ff, prio: run_prio_ff, wake: op_wake_ff};
      slp_raddr     = slp_addr(shead_ff, '0);

      if (psel && penable && pwrite && !paddr[2]) begin
         slice_cfg_in = pwdata[7:0];
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_mode_in = req_mode;
               op_tid_in  = req_thread_id;
               op_prio_in = sat_prio(req_priority_req);
               op_wake_in = req_wake_time;
               op_now_in  = req_now_time;
               err_in     = ERR_NONE;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (op_mode_ff)
               MODE_UNBLOCK: begin
                  push_task_in = op_tid_ff;
                  push_prio_in = op_prio_ff;
                  push_idx_in  = rcount_ff;
                  ret_in       = RET_PRE;
                  if (rcount_ff >= RDY_CW'(RDY_DEPTH)) begin
                     err_in   = ERR_READY_FULL;
                     state_in = ST_PRE;
                  end else begin
                     state_in = ST_PUSH_RD;
                  end
               end
               MODE_SLEEP: begin
                  slp_idx_in = scount_ff;
                  if (run_idle_ff) begin
                     state_in = ST_FIN;
                  end else if (scount_ff >= SLP_CW'(SLP_DEPTH)) begin
                     err_in   = ERR_SLEEP_FULL;
                     state_in = ST_FIN;
                  end else begin
                     state_in = ST_SLP_RD;
                  end
               end
               MODE_TICK: begin
                  state_in = ST_WK_RD;
               end
               MODE_YIELD: begin
                  state_in = ST_YLD;
               end
               MODE_SETPRIO: begin
                  if (run_idle_ff) begin
                     state_in = ST_FIN;
                  end else begin
                     run_prio_in = op_prio_ff;
                     state_in    = ST_PRE;
                  end
               end
               MODE_BLOCK: begin
                  state_in = run_idle_ff ? ST_FIN : ST_DISP;
               end
               default: begin
                  state_in = ST_FIN;
               end
            endcase
         end
         ST_PUSH_RD: begin
            if (push_idx_ff == '0) begin
               rdy_we    = 1'b1;
               rcount_in = rcount_ff + 1'b1;
               case (ret_ff)
                  RET_PRE:  state_in = ST_PRE;
                  RET_WAKE: state_in = ST_WK_EMIT;
                  default:  state_in = ST_FIN;
               endcase
            end else begin
               rdy_raddr = rdy_addr(rhead_ff, push_idx_ff - 1'b1);
               state_in  = ST_PUSH_CMP;
            end
         end
         ST_PUSH_CMP: begin
            rdy_we = 1'b1;
            if (rdy_rdata.prio < push_prio_ff) begin
               rdy_wdata   = rdy_rdata;
               push_idx_in = push_idx_ff - 1'b1;
               state_in    = ST_PUSH_RD;
            end else begin
               rcount_in = rcount_ff + 1'b1;
               case (ret_ff)
                  RET_PRE:  state_in = ST_PRE;
                  RET_WAKE: state_in = ST_WK_EMIT;
                  default:  state_in = ST_FIN;
               endcase
            end
         end
         ST_SLP_RD: begin
            if (slp_idx_ff == '0) begin
               slp_we    = 1'b1;
               scount_in = scount_ff + 1'b1;
               state_in  = ST_DISP;
            end else begin
               slp_raddr = slp_addr(shead_ff, slp_idx_ff - 1'b1);
               state_in  = ST_SLP_CMP;
            end
         end
         ST_SLP_CMP: begin
            slp_we = 1'b1;
            if (slp_rdata.wake > op_wake_ff) begin
               slp_wdata  = slp_rdata;
               slp_idx_in = slp_idx_ff - 1'b1;
               state_in   = ST_SLP_RD;
            end else begin
               scount_in = scount_ff + 1'b1;
               state_in  = ST_DISP;
            end
         end
         ST_WK_RD: begin
            state_in = (scount_ff == '0) ? ST_SLICE : ST_WK_CHK;
         end
         ST_WK_CHK: begin
            if (slp_rdata.wake <= op_now_ff) begin
               shead_in     = (shead_ff == SLP_AW'(SLP_DEPTH - 1)) ? '0 : shead_ff + 1'b1;
               scount_in    = scount_ff - 1'b1;
               push_task_in = slp_rdata.task_id;
               push_prio_in = slp_rdata.prio;
               push_idx_in  = rcount_ff;
               ret_in       = RET_WAKE;
               if (rcount_ff >= RDY_CW'(RDY_DEPTH)) begin
                  wk_err_in = 1'b1;
                  err_in    = ERR_READY_FULL;
                  state_in  = ST_WK_EMIT;
               end else begin
                  wk_err_in = 1'b0;
                  state_in  = ST_PUSH_RD;
               end
            end else begin
               state_in = ST_SLICE;
            end
         end
         ST_WK_EMIT: begin
            out_strobe_in = 1'b1;
            out_kind_in   = KIND_WOKEN;
            out_task_in   = push_task_ff;
            out_prio_in   = push_prio_ff;
            out_idle_in   = 1'b0;
            out_err_in    = wk_err_ff ? ERR_READY_FULL : ERR_NONE;
            out_last_in   = 1'b0;
            state_in      = ST_WK_RD;
         end
         ST_SLICE: begin
            if (run_idle_ff) begin
               state_in = ST_FIN;
            end else begin
               slice_in = slice_next;
               state_in = (slice_next >= slice_cfg_ff) ? ST_YLD : ST_FIN;
            end
         end
         ST_YLD: begin
            if (run_idle_ff) begin
               if (rcount_ff != '0) begin
                  aft_in   = AFT_TAKE;
                  state_in = ST_HD_RD;
               end else begin
                  slice_in = '0;
                  state_in = ST_FIN;
               end
            end else if (rcount_ff == '0) begin
               slice_in = '0;
               state_in = ST_FIN;
            end else begin
               aft_in   = AFT_YLD;
               state_in = ST_HD_RD;
            end
         end
         ST_PRE: begin
            if (rcount_ff == '0) begin
               state_in = ST_FIN;
            end else if (run_idle_ff) begin
               state_in = ST_YLD;
            end else begin
               aft_in   = AFT_PRE;
               state_in = ST_HD_RD;
            end
         end
         ST_DISP: begin
            if (rcount_ff != '0) begin
               aft_in   = AFT_TAKE;
               state_in = ST_HD_RD;
            end else begin
               run_idle_in = 1'b1;
               run_task_in = '0;
               run_prio_in = '0;
               slice_in    = '0;
               state_in    = ST_FIN;
            end
         end
         ST_HD_RD: begin
            state_in = ST_HD_CHK;
         end
         ST_HD_CHK: begin
            if (aft_ff == AFT_TAKE) begin
               run_task_in = rdy_rdata.task_id;
               run_prio_in = rdy_rdata.prio;
               run_idle_in = 1'b0;
               slice_in    = '0;
               rhead_in    = (rhead_ff == RDY_AW'(RDY_DEPTH - 1)) ? '0 : rhead_ff + 1'b1;
               rcount_in   = rcount_ff - 1'b1;
               state_in    = ST_FIN;
            end else if ((aft_ff == AFT_YLD && !(run_prio_ff > rdy_rdata.prio)) ||
                         (aft_ff == AFT_PRE && rdy_rdata.prio > run_prio_ff)) begin
               push_task_in = run_task_ff;
               push_prio_in = run_prio_ff;
               push_idx_in  = rcount_ff - 1'b1;
               ret_in       = RET_FIN;
               run_task_in  = rdy_rdata.task_id;
               run_prio_in  = rdy_rdata.prio;
               run_idle_in  = 1'b0;
               slice_in     = '0;
               rhead_in     = (rhead_ff == RDY_AW'(RDY_DEPTH - 1)) ? '0 : rhead_ff + 1'b1;
               rcount_in    = rcount_ff - 1'b1;
               state_in     = ST_PUSH_RD;
            end else begin
               if (aft_ff == AFT_YLD) begin
                  slice_in = '0;
               end
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (run_idle_ff && rcount_ff != '0) begin
               aft_in   = AFT_TAKE;
               state_in = ST_HD_RD;
            end else begin
               state_in = ST_STATUS;
            end
         end
         ST_STATUS: begin
            out_strobe_in = 1'b1;
            out_kind_in   = KIND_STATUS;
            out_task_in   = run_idle_ff ? '0 : run_task_ff;
            out_prio_in   = run_idle_ff ? '0 : run_prio_ff;
            out_idle_in   = run_idle_ff;
            out_err_in    = err_ff;
            out_last_in   = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         slice_cfg_ff  <= RESET_SLICE;
         run_task_ff   <= RESET_TASK;
         run_prio_ff   <= RESET_PRIO;
         run_idle_ff   <= 1'b0;
         slice_ff      <= '0;
         rhead_ff      <= '0;
         rcount_ff     <= '0;
         shead_ff      <= '0;
         scount_ff     <= '0;
         out_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         slice_cfg_ff  <= slice_cfg_in;
         run_task_ff   <= run_task_in;
         run_prio_ff   <= run_prio_in;
         run_idle_ff   <= run_idle_in;
         slice_ff      <= slice_in;
         rhead_ff      <= rhead_in;
         rcount_ff     <= rcount_in;
         shead_ff      <= shead_in;
         scount_ff     <= scount_in;
         out_strobe_ff <= out_strobe_in;
      end
      ret_ff       <= ret_in;
      aft_ff       <= aft_in;
      op_mode_ff   <= op_mode_in;
      op_tid_ff    <= op_tid_in;
      op_prio_ff   <= op_prio_in;
      op_wake_ff   <= op_wake_in;
      op_now_ff    <= op_now_in;
      err_ff       <= err_in;
      wk_err_ff    <= wk_err_in;
      push_task_ff <= push_task_in;
      push_prio_ff <= push_prio_in;
      push_idx_ff  <= push_idx_in;
      slp_idx_ff   <= slp_idx_in;
      out_kind_ff  <= out_kind_in;
      out_task_ff  <= out_task_in;
      out_prio_ff  <= out_prio_in;
      out_idle_ff  <= out_idle_in;
      out_err_ff   <= out_err_in;
      out_last_ff  <= out_last_in;
   end

   `PRSQ_ASSERT(a_rdy_bound, clock, reset, rcount_ff <= RDY_CW'(RDY_DEPTH))
   `PRSQ_ASSERT(a_slp_bound, clock, reset, scount_ff <= SLP_CW'(SLP_DEPTH))
   `PRSQ_ASSERT_IMP(a_no_write_idle, clock, reset, !busy, !rdy_we && !slp_we)
   `PRSQ_ASSERT_IMP(a_last_is_status, clock, reset, rsp_strobe, rsp_kind == rsp_last)
   `PRSQ_ASSERT_IMP(a_status_ends, clock, reset, rsp_strobe && rsp_last, !busy)

endmodule
`default_nettype wire

// File: tb/sv/prsq_sched_checker.sv
// checker: watches the scheduler channels, predicts every result and compares
`timescale 1ns / 1ps
module prsq_sched_checker import prsq_pkg::*; (
   input  wire               clock,
   input  wire               reset,
   input  wire               start,
   input  wire               busy,
   input  wire [2:0]         req_mode,
   input  wire [TASK_W-1:0]  req_thread_id,
   input  wire [PRIO_W-1:0]  req_priority_req,
   input  wire [TIME_W-1:0]  req_wake_time,
   input  wire [TIME_W-1:0]  req_now_time,
   input  wire               rsp_strobe,
   input  wire               rsp_kind,
   input  wire [TASK_W-1:0]  rsp_task_out,
   input  wire [PRIO_W-1:0]  rsp_task_priority,
   input  wire               rsp_idle_running,
   input  wire [1:0]         rsp_error,
   input  wire               rsp_last,
   input  wire               psel,
   input  wire               penable,
   input  wire               pwrite,
   input  wire [2:0]         paddr,
   input  wire [31:0]        pwdata,
   input  wire               pready,
   output int                fail_count,
   output int                pending
);

   typedef struct packed {
      logic              kind;
      logic [TASK_W-1:0] task_id;
      logic [PRIO_W-1:0] prio;
      logic              idle;
      logic [1:0]        err;
      logic              last;
   } sched_result_type;

   localparam logic [2:0] SLICE_ADDR = 3'd0;

   sched_result_type  expected_results[$];
   rdy_entry_type     ready_q[$];
   slp_entry_type     sleep_q[$];
   logic [TASK_W-1:0] cur_task;
   logic [PRIO_W-1:0] cur_prio;
   logic              cur_idle;
   logic [7:0]        slice_used;
   logic [7:0]        slice_len;

   function automatic bit ready_insert(logic [TASK_W-1:0] t, logic [PRIO_W-1:0] p);
      rdy_entry_type e;
      int pos;
      if (ready_q.size() >= RDY_DEPTH) return 0;
      pos = 0;
      while (pos < ready_q.size() && ready_q[pos].prio >= p) pos++;
      e.task_id = t;
      e.prio = p;
      ready_q.insert(pos, e);
      return 1;
   endfunction

   function automatic void run_ready_head();
      cur_task = ready_q[0].task_id;
      cur_prio = ready_q[0].prio;
      cur_idle = 0;
      void'(ready_q.pop_front());
      slice_used = 0;
   endfunction

   function automatic void run_next();
      if (ready_q.size() > 0) begin
         run_ready_head();
      end else begin
         cur_idle = 1;
         cur_task = 0;
         cur_prio = 0;
         slice_used = 0;
      end
   endfunction

   function automatic void give_way();
      logic [TASK_W-1:0] t;
      logic [PRIO_W-1:0] p;
      if (cur_idle) begin
         run_next();
         return;
      end
      if (ready_q.size() == 0 || cur_prio > ready_q[0].prio) begin
         slice_used = 0;
         return;
      end
      t = cur_task;
      p = cur_prio;
      run_ready_head();
      void'(ready_insert(t, p));
   endfunction

   function automatic void check_preempt();
      if (ready_q.size() > 0 && (cur_idle || ready_q[0].prio > cur_prio)) give_way();
   endfunction

   function automatic void schedule_event(logic [2:0] mode, logic [TASK_W-1:0] tid,
                                          logic [PRIO_W-1:0] prio_in,
                                          logic [TIME_W-1:0] wake, logic [TIME_W-1:0] now);
      logic [1:0] err;
      logic [PRIO_W-1:0] p;
      sched_result_type r;
      slp_entry_type s;
      int pos;
      err = ERR_NONE;
      p = (prio_in > PRIO_MAX) ? PRIO_W'(PRIO_MAX) : prio_in;
      case (mode)
         MODE_UNBLOCK: begin
            if (!ready_insert(tid, p)) err = ERR_READY_FULL;
            check_preempt();
         end
         MODE_SLEEP: begin
            if (!cur_idle) begin
               if (sleep_q.size() >= SLP_DEPTH) begin
                  err = ERR_SLEEP_FULL;
               end else begin
                  pos = 0;
                  while (pos < sleep_q.size() && sleep_q[pos].wake <= wake) pos++;
                  s.task_id = cur_task;
                  s.prio = cur_prio;
                  s.wake = wake;
                  sleep_q.insert(pos, s);
                  run_next();
               end
            end
         end
         MODE_TICK: begin
            while (sleep_q.size() > 0 && sleep_q[0].wake <= now) begin
               s = sleep_q.pop_front();
               r = '0;
               r.kind = KIND_WOKEN;
               r.task_id = s.task_id;
               r.prio = s.prio;
               if (!ready_insert(s.task_id, s.prio)) begin
                  r.err = ERR_READY_FULL;
                  err = ERR_READY_FULL;
               end
               expected_results.push_back(r);
            end
            if (!cur_idle) begin
               if (slice_used != SLICE_SAT) slice_used++;
               if (slice_used >= slice_len) give_way();
            end
         end
         MODE_YIELD: give_way();
         MODE_SETPRIO: begin
            if (!cur_idle) begin
               cur_prio = p;
               check_preempt();
            end
         end
         MODE_BLOCK: begin
            if (!cur_idle) run_next();
         end
         default: ;
      endcase
      if (cur_idle && ready_q.size() > 0) run_ready_head();
      r = '0;
      r.kind = KIND_STATUS;
      r.task_id = cur_idle ? '0 : cur_task;
      r.prio = cur_idle ? '0 : cur_prio;
      r.idle = cur_idle;
      r.err = err;
      r.last = 1;
      expected_results.push_back(r);
   endfunction

   task automatic report(string field, logic [15:0] got, logic [15:0] want);
      fail_count++;
      if (fail_count <= 40)
         $display("%0t mismatch %s: got %0d expected %0d", $realtime, field, got, want);
   endtask

   task automatic compare_result();
      sched_result_type w;
      if (expected_results.size() == 0) begin
         report("unexpected transaction", rsp_task_out, 0);
         return;
      end
      w = expected_results.pop_front();
      if (rsp_kind !== w.kind) report("kind", rsp_kind, w.kind);
      if (rsp_task_out !== w.task_id) report("task_out", rsp_task_out, w.task_id);
      if (rsp_task_priority !== w.prio) report("task_priority", rsp_task_priority, w.prio);
      if (rsp_idle_running !== w.idle) report("idle_running", rsp_idle_running, w.idle);
      if (rsp_error !== w.err) report("error", rsp_error, w.err);
      if (rsp_last !== w.last) report("last", rsp_last, w.last);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_results.delete();
         ready_q.delete();
         sleep_q.delete();
         cur_task = RESET_TASK;
         cur_prio = RESET_PRIO;
         cur_idle = 0;
         slice_used = 0;
         slice_len = RESET_SLICE;
         fail_count = 0;
      end else begin
         if (rsp_strobe === 1'b1) compare_result();
         if (psel && penable && pwrite && pready && paddr == SLICE_ADDR)
            slice_len = pwdata[7:0];
         if (start && busy === 1'b0)
            schedule_event(req_mode, req_thread_id, req_priority_req,
                           req_wake_time, req_now_time);
      end
      pending = expected_results.size();
   end

endmodule

// File: tb/sv/priority_ready_and_sleep_queue_top_tb.sv
// testbench top: clock, reset, stimulus, watchdog and verdict for the scheduler
`timescale 1ns / 1ps
module priority_ready_and_sleep_queue_top_tb;
   import prsq_pkg::*;

   localparam int QUIET_LIMIT = 4000;
   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [2:0]         req_mode;
   logic [TASK_W-1:0]  req_thread_id;
   logic [PRIO_W-1:0]  req_priority_req;
   logic [TIME_W-1:0]  req_wake_time;
   logic [TIME_W-1:0]  req_now_time;
   logic               rsp_strobe;
   logic               rsp_kind;
   logic [TASK_W-1:0]  rsp_task_out;
   logic [PRIO_W-1:0]  rsp_task_priority;
   logic               rsp_idle_running;
   logic [1:0]         rsp_error;
   logic               rsp_last;
   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [2:0]         paddr;
   logic [31:0]        pwdata;
   logic [31:0]        prdata;
   logic               pready;
   int                 fail_count;
   int                 pending;
   int                 quiet_cycles;
   int                 idle_pct;
   logic [TIME_W-1:0]  tick_now;

   priority_ready_and_sleep_queue_top dut (.*);

   prsq_sched_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [TIME_W-1:0] rand_time();
      return TIME_W'({$urandom, $urandom});
   endfunction

   task automatic send(logic [2:0] mode, logic [TASK_W-1:0] tid, logic [PRIO_W-1:0] p,
                       logic [TIME_W-1:0] wake, logic [TIME_W-1:0] now);
      int gap;
      gap = 0;
      if ($urandom_range(99) < idle_pct) gap = $urandom_range(1, 8);
      if (gap > 0) begin
         @(negedge clock);
         start = 0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_mode = mode;
      req_thread_id = tid;
      req_priority_req = p;
      req_wake_time = wake;
      req_now_time = now;
      start = 1;
      while (busy) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic drain();
      @(negedge clock);
      start = 0;
      while (pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic csr_write(logic [31:0] value);
      @(negedge clock);
      psel = 1;
      penable = 0;
      pwrite = 1;
      paddr = 3'd0;
      pwdata = value;
      @(negedge clock);
      penable = 1;
      @(negedge clock);
      psel = 0;
      penable = 0;
      pwrite = 0;
   endtask

   task automatic random_transaction();
      int sel;
      logic [TASK_W-1:0] tid;
      logic [PRIO_W-1:0] pr;
      sel = $urandom_range(99);
      tid = TASK_W'($urandom);
      pr = PRIO_W'($urandom);
      if (sel < 30) begin
         send(MODE_UNBLOCK, tid, pr, rand_time(), rand_time());
      end else if (sel < 55) begin
         if ($urandom_range(19) == 0) tick_now = rand_time() >> $urandom_range(62);
         else tick_now = tick_now + TIME_W'($urandom_range(0, 3));
         send(MODE_TICK, tid, pr, rand_time(), tick_now);
      end else if (sel < 72) begin
         if ($urandom_range(19) == 0)
            send(MODE_SLEEP, tid, pr, rand_time(), rand_time());
         else
            send(MODE_SLEEP, tid, pr, tick_now + TIME_W'($urandom_range(0, 8)),
                 rand_time());
      end else if (sel < 82) begin
         send(MODE_YIELD, tid, pr, rand_time(), rand_time());
      end else if (sel < 92) begin
         send(MODE_SETPRIO, tid, pr, rand_time(), rand_time());
      end else begin
         send(MODE_BLOCK, tid, pr, rand_time(), rand_time());
      end
   endtask

   initial begin
      reset = 1;
      start = 0;
      req_mode = MODE_UNBLOCK;
      req_thread_id = 0;
      req_priority_req = 0;
      req_wake_time = 0;
      req_now_time = 0;
      psel = 0;
      penable = 0;
      pwrite = 0;
      paddr = 0;
      pwdata = 0;
      idle_pct = 0;
      tick_now = 0;
      repeat (6) @(negedge clock);
      reset = 0;

      // directed: fill and overflow both queues, idle requests, wake all
      csr_write(2);
      send(MODE_SETPRIO, 0, 6'd63, 0, 0);
      send(MODE_UNBLOCK, 8'd0, 6'd0, 0, 0);
      send(MODE_UNBLOCK, 8'd255, 6'd63, 0, 0);
      for (int i = 0; i < 15; i++) send(MODE_UNBLOCK, 8'(i + 2), 6'(i * 4), 0, 0);
      for (int i = 0; i < 17; i++)
         send(MODE_SLEEP, 0, 0, (i % 3 == 0) ? '0 : (i % 3 == 1) ? TIME_MAX : rand_time(),
              TIME_MAX);
      send(MODE_BLOCK, 0, 0, 0, 0);
      send(MODE_BLOCK, 0, 0, 0, 0);
      send(MODE_SLEEP, 0, 0, 0, 0);
      send(MODE_SETPRIO, 0, 6'd5, 0, 0);
      send(MODE_YIELD, 0, 0, 0, 0);
      send(MODE_TICK, 0, 0, TIME_MAX, TIME_MAX);
      send(MODE_YIELD, 0, 0, 0, 0);
      send(MODE_SETPRIO, 0, 6'd0, 0, 0);
      send(MODE_TICK, 0, 0, 0, 0);
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  csr_write(1); end
            1: begin idle_pct = 74; csr_write(255); end
            2: begin idle_pct = 0;  csr_write($urandom_range(1, 255)); end
            default: begin idle_pct = 29; csr_write(4); end
         endcase
         for (int n = 0; n < 103; n++) random_transaction();
         drain();
      end

      if (fail_count == 0 && pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
